FILE: rtl/core/wzcr_pkg.sv
`timescale 1ns / 1ps

package wzcr_pkg;

	localparam int RATE_W  = 17;
	localparam int FRAC_W  = 16;
	localparam int CFG_W   = 17;
	localparam int LEN_W   = 11;
	localparam int CNT_W   = 32;
	localparam int IDX_W   = 2;

	typedef enum logic [IDX_W-1:0] {
		CFG_WINDOW    = 2'd0,
		CFG_MIN_FILL  = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_idx_t;

	localparam logic [LEN_W-1:0]  WINDOW_RST    = 11'd64;
	localparam logic [LEN_W-1:0]  MIN_FILL_RST  = 11'd8;
	localparam logic [RATE_W-1:0] THRESHOLD_RST = 17'd6554;

	typedef logic [RATE_W-1:0] rate_t;
	typedef logic [CNT_W-1:0]  count_t;

endpackage

FILE: rtl/core/wzcr_if.sv
`timescale 1ns / 1ps

interface wzcr_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface wzcr_out_if;
	logic                  valid;
	logic                  ready;
	wzcr_pkg::rate_t       rate;
	logic                  rate_ready;
	logic                  change_flag;
	wzcr_pkg::rate_t       previous_rate;
	wzcr_pkg::count_t      change_count;
	wzcr_pkg::count_t      sample_count;

	modport source (output valid, output rate, output rate_ready, output change_flag,
		output previous_rate, output change_count, output sample_count, input ready);
	modport sink   (input valid, input rate, input rate_ready, input change_flag,
		input previous_rate, input change_count, input sample_count, output ready);
endinterface

FILE: rtl/core/wzcr_ring.sv
`timescale 1ns / 1ps

module wzcr_ring #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic                     rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic                     wr_data
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/wzcr_div.sv
`timescale 1ns / 1ps

module wzcr_div #(
	parameter int FILL_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [FILL_W-1:0]       num,
	input  logic [FILL_W-1:0]       den,
	output logic                    done,
	output wzcr_pkg::rate_t         quot
);

	localparam int STEPS = wzcr_pkg::RATE_W;
	localparam int CNT_W = $clog2(STEPS);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FILL_W:0]   rem_q;
	logic [FILL_W-1:0] den_q;
	wzcr_pkg::rate_t   quot_q;
	logic              done_q;
	logic              take;
	logic [FILL_W:0]   rem_next;

	assign take     = rem_q >= {1'b0, den_q};
	assign rem_next = take ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q  <= {rem_next[FILL_W-1:0], 1'b0};
			quot_q <= {quot_q[STEPS-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: rtl/core/windowed_zero_crossing_rate.sv
`timescale 1ns / 1ps
// Channel   Role    Payload
// in_ch     sink    sample
// out_ch    source  rate, rate_ready, change_flag, previous_rate, change_count, sample_count
// cfg_*     write   cfg_index, cfg_data (no read-back)
//
// A transaction runs from accept to next accept through the accept state, one ring
// update, the divider (17 shift-subtract steps, then done) and one post state.
// Before min_fill is reached the divider is skipped.
// Reset is asynchronous; the ring needs no clearing pass, the fill level masks stale bits.
// A stalled out_ch holds the output register; the next transaction is taken, then
// waits in its post cycle with in_ch.ready low until the output register frees.

module windowed_zero_crossing_rate #(
	parameter int WINDOW_MAX  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [wzcr_pkg::IDX_W-1:0]             cfg_index,
	input  logic [wzcr_pkg::CFG_W-1:0]             cfg_data,
	wzcr_in_if.sink                                in_ch,
	wzcr_out_if.source                             out_ch
);

	localparam int HEAD_W = $clog2(WINDOW_MAX);
	localparam int FILL_W = $clog2(WINDOW_MAX + 1);

	typedef enum logic [1:0] {S_IDLE, S_UPD, S_DIV, S_FIN} state_t;

	state_t                           state_q;
	logic [wzcr_pkg::LEN_W-1:0]       window_q;
	logic [wzcr_pkg::LEN_W-1:0]       min_fill_q;
	wzcr_pkg::rate_t                  thresh_q;
	logic [HEAD_W-1:0]                head_q;
	logic [FILL_W-1:0]                fill_q;
	logic [FILL_W-1:0]                total_q;
	logic                             last_neg_q;
	logic                             seen_q;
	logic                             bit_q;
	logic                             ready_q;
	wzcr_pkg::rate_t                  last_rate_q;
	logic                             last_valid_q;
	wzcr_pkg::count_t                 events_q;
	wzcr_pkg::count_t                 samples_q;

	logic                             out_valid_q;
	wzcr_pkg::rate_t                  out_rate_q;
	logic                             out_ready_flag_q;
	logic                             out_change_q;
	wzcr_pkg::rate_t                  out_prev_q;

	logic [FILL_W-1:0]                win_eff;
	logic                             accept;
	logic                             neg;
	logic                             ring_rd;
	logic                             old_bit;
	logic [FILL_W-1:0]                total_n;
	logic [FILL_W-1:0]                fill_n;
	logic [FILL_W-1:0]                head_inc;
	logic                             ready_n;
	logic                             div_start;
	logic                             div_done;
	wzcr_pkg::rate_t                  div_quot;
	wzcr_pkg::rate_t                  rate_fin;
	wzcr_pkg::rate_t                  diff;
	logic                             change_fin;
	logic                             out_free;
	logic                             cfg_clear;

	always_comb begin
		if (window_q == '0) begin
			win_eff = FILL_W'(1);
		end else if (32'(window_q) > 32'(WINDOW_MAX)) begin
			win_eff = FILL_W'(WINDOW_MAX);
		end else begin
			win_eff = FILL_W'(window_q);
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign neg         = in_ch.sample[SAMPLE_BITS-1];
	assign cfg_clear   = cfg_we && (cfg_index == wzcr_pkg::CFG_WINDOW
		|| cfg_index == wzcr_pkg::CFG_MIN_FILL);

	assign old_bit  = (fill_q == win_eff) ? ring_rd : 1'b0;
	assign total_n  = total_q - FILL_W'(old_bit) + FILL_W'(bit_q);
	assign fill_n   = (fill_q < win_eff) ? fill_q + 1'b1 : fill_q;
	assign head_inc = FILL_W'(head_q) + 1'b1;
	assign ready_n  = 32'(fill_n) >= 32'(min_fill_q);

	assign div_start = (state_q == S_UPD) && ready_n;

	assign rate_fin   = ready_q ? div_quot : '0;
	assign diff       = (rate_fin > last_rate_q) ? rate_fin - last_rate_q
		: last_rate_q - rate_fin;
	assign change_fin = ready_q && last_valid_q && (diff > thresh_q);
	assign out_free   = !out_valid_q || out_ch.ready;

	wzcr_ring #(.DEPTH(WINDOW_MAX)) u_ring (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (head_q),
		.rd_data (ring_rd),
		.wr_en   (state_q == S_UPD),
		.wr_addr (head_q),
		.wr_data (bit_q)
	);

	wzcr_div #(.FILL_W(FILL_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (total_n),
		.den    (fill_n),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			window_q         <= wzcr_pkg::WINDOW_RST;
			min_fill_q       <= wzcr_pkg::MIN_FILL_RST;
			thresh_q         <= wzcr_pkg::THRESHOLD_RST;
			head_q           <= '0;
			fill_q           <= '0;
			total_q          <= '0;
			last_neg_q       <= 1'b0;
			seen_q           <= 1'b0;
			bit_q            <= 1'b0;
			ready_q          <= 1'b0;
			last_rate_q      <= '0;
			last_valid_q     <= 1'b0;
			events_q         <= '0;
			samples_q        <= '0;
			out_valid_q      <= 1'b0;
			out_rate_q       <= '0;
			out_ready_flag_q <= 1'b0;
			out_change_q     <= 1'b0;
			out_prev_q       <= '0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					wzcr_pkg::CFG_WINDOW:    window_q   <= cfg_data[wzcr_pkg::LEN_W-1:0];
					wzcr_pkg::CFG_MIN_FILL:  min_fill_q <= cfg_data[wzcr_pkg::LEN_W-1:0];
					wzcr_pkg::CFG_THRESHOLD: thresh_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_clear) begin
				head_q  <= '0;
				fill_q  <= '0;
				total_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						bit_q      <= seen_q && (neg != last_neg_q);
						seen_q     <= 1'b1;
						last_neg_q <= neg;
						state_q    <= S_UPD;
					end
				end
				S_UPD: begin
					total_q <= total_n;
					fill_q  <= fill_n;
					head_q  <= (head_inc >= win_eff) ? '0 : head_inc[HEAD_W-1:0];
					ready_q <= ready_n;
					state_q <= ready_n ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_rate_q       <= rate_fin;
						out_ready_flag_q <= ready_q;
						out_change_q     <= change_fin;
						out_prev_q       <= last_valid_q ? last_rate_q : '0;
						samples_q        <= samples_q + 1'b1;
						if (change_fin) begin
							events_q <= events_q + 1'b1;
						end
						if (ready_q) begin
							last_rate_q  <= rate_fin;
							last_valid_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.rate          = out_rate_q;
	assign out_ch.rate_ready    = out_ready_flag_q;
	assign out_ch.change_flag   = out_change_q;
	assign out_ch.previous_rate = out_prev_q;
	assign out_ch.change_count  = events_q;
	assign out_ch.sample_count  = samples_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_eff)
		else $error("fill level beyond window");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(head_q) < win_eff)
		else $error("ring head outside window");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= fill_q)
		else $error("crossing count above fill level");

	a_rate_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_rate_q <= wzcr_pkg::rate_t'(1 << wzcr_pkg::FRAC_W)))
		else $error("rate above one");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready_flag_q) |-> (out_rate_q == '0 && !out_change_q))
		else $error("rate posted while not ready");

endmodule

FILE: tb/zcr_rate_scoreboard.sv
`timescale 1ns / 1ps

module zcr_rate_scoreboard (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wzcr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [wzcr_pkg::CFG_W-1:0]   cfg_data,
	wzcr_in_if                           in_ch,
	wzcr_out_if                          out_ch,
	output int                           failures,
	output int                           pending
);

	localparam int WINDOW_DEPTH = 1024;
	localparam int SIGN_BIT     = 15;

	typedef struct packed {
		wzcr_pkg::rate_t  rate;
		logic             rate_ready;
		logic             change_flag;
		wzcr_pkg::rate_t  previous_rate;
		wzcr_pkg::count_t change_count;
		wzcr_pkg::count_t sample_count;
	} zcr_result_t;

	zcr_result_t expected_rates[$];
	zcr_result_t oldest;

	bit                         window_bits[WINDOW_DEPTH];
	int unsigned                head;
	int unsigned                fill;
	int unsigned                crossing_sum;
	logic                       prior_neg;
	logic                       have_prior;
	wzcr_pkg::rate_t            held_rate;
	logic                       held_rate_valid;
	wzcr_pkg::count_t           change_events;
	wzcr_pkg::count_t           sample_total;
	logic [wzcr_pkg::LEN_W-1:0] window_len;
	logic [wzcr_pkg::LEN_W-1:0] fill_needed;
	wzcr_pkg::rate_t            threshold;

	task automatic clear_window();
		foreach (window_bits[i]) window_bits[i] = 1'b0;
		head         = 0;
		fill         = 0;
		crossing_sum = 0;
	endtask

	task automatic reset_model();
		clear_window();
		prior_neg       = 1'b0;
		have_prior      = 1'b0;
		held_rate       = '0;
		held_rate_valid = 1'b0;
		change_events   = '0;
		sample_total    = '0;
		window_len      = wzcr_pkg::WINDOW_RST;
		fill_needed     = wzcr_pkg::MIN_FILL_RST;
		threshold       = wzcr_pkg::THRESHOLD_RST;
	endtask

	task automatic apply_write(input logic [wzcr_pkg::IDX_W-1:0] idx,
		input logic [wzcr_pkg::CFG_W-1:0] data);
		case (idx)
			wzcr_pkg::CFG_WINDOW: begin
				window_len = data[wzcr_pkg::LEN_W-1:0];
				clear_window();
			end
			wzcr_pkg::CFG_MIN_FILL: begin
				fill_needed = data[wzcr_pkg::LEN_W-1:0];
				clear_window();
			end
			wzcr_pkg::CFG_THRESHOLD: begin
				threshold = data[wzcr_pkg::RATE_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	function automatic zcr_result_t predict_crossing_rate(input logic signed [15:0] sample);
		zcr_result_t       r;
		int unsigned       win;
		logic              neg;
		logic              crossed;
		longint unsigned   quotient;
		wzcr_pkg::rate_t   delta;
		r = '0;
		if (window_len == 0)
			win = 1;
		else if (window_len > WINDOW_DEPTH)
			win = WINDOW_DEPTH;
		else
			win = window_len;
		neg = sample[SIGN_BIT];
		crossed = have_prior && (neg != prior_neg);
		have_prior = 1'b1;
		prior_neg = neg;
		r.previous_rate = held_rate_valid ? held_rate : '0;

		if (head >= win) head = 0;
		crossing_sum = crossing_sum - window_bits[head];
		window_bits[head] = crossed;
		crossing_sum = crossing_sum + crossed;
		head++;
		if (head >= win) head = 0;
		if (fill < win) fill++;

		if (fill >= fill_needed && fill != 0) begin
			r.rate_ready = 1'b1;
			quotient = (longint'(crossing_sum) << wzcr_pkg::FRAC_W) / fill;
			if (quotient > 65536) quotient = 65536;
			r.rate = quotient[wzcr_pkg::RATE_W-1:0];
			if (held_rate_valid) begin
				delta = (r.rate > held_rate) ? r.rate - held_rate : held_rate - r.rate;
				if (delta > threshold) begin
					r.change_flag = 1'b1;
					change_events++;
				end
			end
			held_rate = r.rate;
			held_rate_valid = 1'b1;
		end
		sample_total++;
		r.change_count = change_events;
		r.sample_count = sample_total;
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_model();
			expected_rates.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (cfg_we) apply_write(cfg_index, cfg_data);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_rates.size() == 0) begin
					$error("result transaction with no expectation waiting");
					failures++;
				end else begin
					oldest = expected_rates.pop_front();
					check_field("rate", oldest.rate, out_ch.rate);
					check_field("rate_ready", oldest.rate_ready, out_ch.rate_ready);
					check_field("change_flag", oldest.change_flag, out_ch.change_flag);
					check_field("previous_rate", oldest.previous_rate, out_ch.previous_rate);
					check_field("change_count", oldest.change_count, out_ch.change_count);
					check_field("sample_count", oldest.sample_count, out_ch.sample_count);
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_rates.push_back(predict_crossing_rate(in_ch.sample));
			pending = expected_rates.size();
		end
	end

endmodule

FILE: tb/windowed_zero_crossing_rate_tb.sv
`timescale 1ns / 1ps

module windowed_zero_crossing_rate_tb;

	localparam logic [wzcr_pkg::IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int PRESSURE_AT   = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 60;
	localparam int NUM_FIXED     = 6;
	localparam int NUM_RANDOM    = 4;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [wzcr_pkg::IDX_W-1:0] cfg_index;
	logic [wzcr_pkg::CFG_W-1:0] cfg_data;
	int                         failures;
	int                         pending;
	int                         sent;
	int                         flip_pct;
	logic                       stim_neg;

	int directed_samples[18] = '{-32768, -1, 0, 32767, -1, 1, -2, 0, 32767, -32768,
		-32768, 1, -1, 0, -32768, 32767, 12345, -12345};

	int fixed_win[NUM_FIXED]   = '{1, 0, 1024, 2047, 5, 1024};
	int fixed_fill[NUM_FIXED]  = '{1, 0, 1, 0, 9, 1024};
	int fixed_thr[NUM_FIXED]   = '{0, 1, 65536, 131071, 100, 0};
	int fixed_items[NUM_FIXED] = '{30, 30, 60, 30, 25, 20};

	always #10 clk = ~clk;

	wzcr_in_if #(.SAMPLE_BITS(16)) in_ch ();
	wzcr_out_if out_ch ();

	windowed_zero_crossing_rate #(
		.WINDOW_MAX(1024),
		.SAMPLE_BITS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	zcr_rate_scoreboard scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.failures(failures),
		.pending(pending)
	);

	function automatic logic signed [15:0] next_sample();
		int pick;
		if ($urandom_range(0, 99) < flip_pct) stim_neg = ~stim_neg;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return stim_neg ? -16'sd32768 : 16'sd32767;
		if (pick == 1)
			return stim_neg ? -16'sd1 : 16'sd0;
		if (pick == 2)
			return 16'($urandom);
		if (stim_neg)
			return 16'(-int'($urandom_range(1, 32768)));
		return 16'($urandom_range(0, 32767));
	endfunction

	task automatic send_sample(input logic signed [15:0] sample);
		int gap;
		gap = (((sent / 40) % 4) == 1) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= sample;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	task automatic run_samples(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0) flip_pct = $urandom_range(0, 100);
			send_sample(next_sample());
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	task automatic write_reg(input logic [wzcr_pkg::IDX_W-1:0] idx,
		input logic [wzcr_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int win, input int fill, input int thr, input bit keep_ring);
		if (!keep_ring) begin
			write_reg(wzcr_pkg::CFG_WINDOW, {6'($urandom_range(0, 63)), 11'(win)});
			write_reg(wzcr_pkg::CFG_MIN_FILL, {6'($urandom_range(0, 63)), 11'(fill)});
		end
		write_reg(wzcr_pkg::CFG_THRESHOLD, 17'(thr));
		write_reg(CFG_SPARE, 17'($urandom));
	endtask

	initial begin
		int taken;
		int gap;
		taken = 0;
		gap = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				taken++;
				if (taken == PRESSURE_AT)
					gap = HOLD_CYCLES;
				else if (((taken / 50) % 4) == 3)
					gap = 0;
				else
					gap = $urandom_range(0, 10);
				out_ch.ready <= (gap == 0);
			end else if (!out_ch.ready) begin
				if (gap <= 1) begin
					gap = 0;
					out_ch.ready <= 1'b1;
				end else begin
					gap--;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int win;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = wzcr_pkg::CFG_WINDOW;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		sent = 0;
		flip_pct = 50;
		stim_neg = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_samples[i]) send_sample(16'(directed_samples[i]));
		run_samples(80);
		drain();

		for (int p = 0; p < NUM_FIXED; p++) begin
			configure(fixed_win[p], fixed_fill[p], fixed_thr[p], 1'b0);
			run_samples(fixed_items[p]);
			drain();
		end

		for (int p = 0; p < NUM_RANDOM; p++) begin
			win = $urandom_range(2, 48);
			configure(win, $urandom_range(1, win), $urandom_range(0, 20000),
				(p > 0) && $urandom_range(0, 1));
			run_samples(60);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
